// ===== rtl/kmpsm_pkg.sv =====
`default_nettype none

package kmpsm_pkg;

	// step counter of the control program
	localparam int STEP_W = 3;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_FETCH    = 3'd0;
	localparam step_t STEP_START    = 3'd1;
	localparam step_t STEP_READ     = 3'd2;
	localparam step_t STEP_CMP      = 3'd3;
	localparam step_t STEP_FINISH   = 3'd4;
	localparam step_t STEP_FALLBACK = 3'd5;

	// datapath operation selected by a control word
	typedef enum logic [2:0] {
		OP_FETCH,
		OP_START,
		OP_READ,
		OP_STEP,
		OP_FINISH,
		OP_FALLBACK
	} op_t;

	// branch condition selected by a control word
	typedef enum logic [2:0] {
		C_ALWAYS,
		C_NO_ACCEPT,
		C_START_DONE,
		C_WALK,
		C_NOT_FULL
	} cond_t;

	// one control word: operation, condition, target if true, target if false
	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t tgt_t;
		step_t tgt_f;
	} uword_t;

	// control program ROM
	function automatic uword_t ucode(input step_t s);
		uword_t w;
		begin
			case (s)
				STEP_FETCH:    w = '{OP_FETCH,    C_NO_ACCEPT,  STEP_FETCH, STEP_START};
				STEP_START:    w = '{OP_START,    C_START_DONE, STEP_FETCH, STEP_READ};
				STEP_READ:     w = '{OP_READ,     C_ALWAYS,     STEP_CMP,   STEP_CMP};
				STEP_CMP:      w = '{OP_STEP,     C_WALK,       STEP_READ,  STEP_FINISH};
				STEP_FINISH:   w = '{OP_FINISH,   C_NOT_FULL,   STEP_FETCH, STEP_FALLBACK};
				STEP_FALLBACK: w = '{OP_FALLBACK, C_ALWAYS,     STEP_FETCH, STEP_FETCH};
				default:       w = '{OP_FETCH,    C_ALWAYS,     STEP_FETCH, STEP_FETCH};
			endcase
			return w;
		end
	endfunction

endpackage

`default_nettype wire

// ===== rtl/kmpsm_ram.sv =====
`default_nettype none

module kmpsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/kmp_stream_matcher_core.sv =====
`default_nettype none

// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: data_byte; tuser: mode, first
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: match_start
//
// One word at a time, stepped by a small control ROM. A text word runs fetch,
// start, read, compare and finish, repeating read and compare per failure-link
// walk, and a fallback on a full match; a pattern word that extends the pattern
// runs the same steps bar the fallback; a new or dropped pattern word or a text
// word with no pattern only fetch and start. Walks repeat both steps as the
// pattern and failure RAMs have a registered read. Reset clears lengths, match
// state and position, not the RAMs. A full match waits only while a previous
// result is still held on m_axis; input words are taken while a result waits.

module kmp_stream_matcher_core #(
	parameter int MAX_PATTERN    = 256,
	parameter int POSITION_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  wire logic [1:0]  s_axis_tuser,   // [0] mode, [1] first
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [31:0] m_axis_tdata    // [31:0] match_start
);

	localparam int AW = $clog2(MAX_PATTERN);
	localparam int LW = $clog2(MAX_PATTERN + 1);
	localparam int PW = POSITION_WIDTH;
	localparam int SW = (PW > LW) ? PW : LW;
	localparam int MW = (PW > 32) ? PW : 32;

	// control state
	kmpsm_pkg::step_t  upc_q;
	kmpsm_pkg::uword_t uw;
	logic [LW-1:0]     len_q;
	logic [AW-1:0]     prefix_q;
	logic [AW-1:0]     matched_q;
	logic [LW-1:0]     j_q;
	logic [PW-1:0]     text_pos_q;
	logic              out_valid_q;

	// latched word and result
	logic [7:0]        c_q;
	logic              mode_q;
	logic              first_q;
	logic [PW-1:0]     pos_cur_q;
	logic [31:0]       match_start_q;

	// RAM ports
	logic              p_we, f_we;
	logic [AW-1:0]     p_waddr, f_waddr, p_raddr, f_raddr;
	logic [AW-1:0]     f_wdata;
	logic [7:0]        p_rdata;
	logic [AW-1:0]     f_rdata;

	logic              accept, walk, full, hold, cond_ok, start_done, out_set;
	logic [PW-1:0]     pos_eff;
	logic [LW-1:0]     j_dec, len_dec;
	logic [SW-1:0]     back_w, pos_w, start_w;
	logic [MW-1:0]     start_ext;

	kmpsm_ram #(.WIDTH(8), .DEPTH(MAX_PATTERN)) u_pat_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (c_q),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	kmpsm_ram #(.WIDTH(AW), .DEPTH(MAX_PATTERN)) u_fail_ram (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_waddr),
		.wdata (f_wdata),
		.raddr (f_raddr),
		.rdata (f_rdata)
	);

	assign uw            = kmpsm_pkg::ucode(upc_q);
	assign s_axis_tready = (uw.op == kmpsm_pkg::OP_FETCH);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = match_start_q;

	// datapath flags
	assign walk    = (j_q != '0) && (p_rdata != c_q);
	assign full    = mode_q && (j_q == len_q);
	assign hold    = (uw.op == kmpsm_pkg::OP_FINISH) && full && out_valid_q && !m_axis_tready;
	assign out_set = (uw.op == kmpsm_pkg::OP_FINISH) && full && !hold;
	assign pos_eff = first_q ? '0 : text_pos_q;
	assign j_dec   = j_q - LW'(1);
	assign len_dec = len_q - LW'(1);
	assign start_done = mode_q ? (len_q == '0)
	                           : (first_q || (len_q == '0) || (len_q == LW'(MAX_PATTERN)));

	// start position of a full match, clamped at zero
	assign back_w    = SW'(len_dec);
	assign pos_w     = SW'(pos_cur_q);
	assign start_w   = (pos_w >= back_w) ? (pos_w - back_w) : '0;
	assign start_ext = MW'(start_w[PW-1:0]);

	// branch condition
	always_comb begin
		case (uw.cond)
			kmpsm_pkg::C_ALWAYS:     cond_ok = 1'b1;
			kmpsm_pkg::C_NO_ACCEPT:  cond_ok = !accept;
			kmpsm_pkg::C_START_DONE: cond_ok = start_done;
			kmpsm_pkg::C_WALK:       cond_ok = walk;
			kmpsm_pkg::C_NOT_FULL:   cond_ok = !full;
			default:                 cond_ok = 1'b1;
		endcase
	end

	// RAM addressing per step
	always_comb begin
		p_we    = 1'b0;
		p_waddr = len_q[AW-1:0];
		f_we    = 1'b0;
		f_waddr = len_q[AW-1:0];
		f_wdata = j_q[AW-1:0];
		p_raddr = j_q[AW-1:0];
		f_raddr = j_dec[AW-1:0];
		case (uw.op)
			kmpsm_pkg::OP_START: begin
				if (!mode_q) begin
					if (first_q || (len_q == '0)) begin
						p_we    = 1'b1;
						p_waddr = '0;
						f_we    = 1'b1;
						f_waddr = '0;
						f_wdata = '0;
					end else if (len_q != LW'(MAX_PATTERN)) begin
						p_we = 1'b1;
					end
				end
			end
			kmpsm_pkg::OP_FINISH: begin
				f_we    = !mode_q;
				f_raddr = len_dec[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	// sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q       <= kmpsm_pkg::STEP_FETCH;
			len_q       <= '0;
			prefix_q    <= '0;
			matched_q   <= '0;
			j_q         <= '0;
			text_pos_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (!hold) begin
				upc_q <= cond_ok ? uw.tgt_t : uw.tgt_f;
			end
			// result register: a new match replaces a word taken this cycle
			if (out_set) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (uw.op)
				kmpsm_pkg::OP_START: begin
					if (mode_q) begin
						text_pos_q <= (pos_eff == '1) ? pos_eff : pos_eff + PW'(1);
						if (len_q == '0) begin
							matched_q <= '0;
						end
						j_q <= (first_q || (LW'(matched_q) >= len_q)) ? '0 : LW'(matched_q);
					end else if (first_q || (len_q == '0)) begin
						len_q     <= LW'(1);
						prefix_q  <= '0;
						matched_q <= '0;
					end else begin
						j_q <= LW'(prefix_q);
					end
				end
				kmpsm_pkg::OP_STEP: begin
					if (walk) begin
						j_q <= LW'(f_rdata);
					end else if (p_rdata == c_q) begin
						j_q <= j_q + LW'(1);
					end
				end
				kmpsm_pkg::OP_FINISH: begin
					if (!hold) begin
						if (!mode_q) begin
							prefix_q <= j_q[AW-1:0];
							len_q    <= len_q + LW'(1);
						end else if (!full) begin
							matched_q <= j_q[AW-1:0];
						end
					end
				end
				kmpsm_pkg::OP_FALLBACK: begin
					matched_q <= f_rdata;
				end
				default: begin
				end
			endcase
		end
	end

	// latched word, current position and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			c_q     <= s_axis_tdata;
			mode_q  <= s_axis_tuser[0];
			first_q <= s_axis_tuser[1];
		end
		if ((uw.op == kmpsm_pkg::OP_START) && mode_q) begin
			pos_cur_q <= pos_eff;
		end
		if (out_set) begin
			match_start_q <= start_ext[31:0];
		end
	end

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PAT_CAP      = 256;
	localparam int POS_BITS     = 32;
	localparam int STALL_LIMIT  = 5000;  // cycles with no word moving on either side
	localparam int DRAIN_CYCLES = 600;   // longest failure walk on a full-size pattern
	localparam int REPORT_MAX   = 10;
	localparam int IDLE_PCT     = 22;

	localparam bit MODE_PATTERN = 1'b0;
	localparam bit MODE_TEXT    = 1'b1;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	wire         s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] data_byte
	logic [1:0]  s_axis_tuser  = 2'b00;  // [0] mode, [1] first
	wire         m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	wire  [31:0] m_axis_tdata;           // [31:0] match_start

	// matcher state as the bench sees it
	logic [7:0]          pat_mem  [PAT_CAP];
	int                  link_mem [PAT_CAP];
	int                  pat_len;
	int                  pfx_len;
	int                  matched;
	logic [POS_BITS-1:0] text_pos;

	logic [31:0] match_starts_q[$];
	logic [31:0] want_start;
	int          fail_count;
	int          idle_cycles;
	bit          calm;

	// random-stimulus helpers: current pattern and its alphabet
	logic [7:0] cur_pat[$];
	logic [7:0] alpha_base;
	int         alpha_n;

	kmp_stream_matcher_core #(
		.MAX_PATTERN   (PAT_CAP),
		.POSITION_WIDTH(POS_BITS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// KMP step on one accepted word; returns 1 with the start position on a full match
	function automatic bit kmp_step(input bit is_text, input logic [7:0] ch, input bit fresh,
			output logic [31:0] hit_pos);
		int k;
		int p;
		int back;
		hit_pos = '0;
		if (!is_text) begin
			if (fresh || pat_len == 0) begin
				pat_mem[0]  = ch;
				link_mem[0] = 0;
				pat_len     = 1;
				pfx_len     = 0;
				matched     = 0;
				return 1'b0;
			end
			if (pat_len >= PAT_CAP)
				return 1'b0;
			pat_mem[pat_len] = ch;
			k = pfx_len;
			while (k > 0 && pat_mem[k] != ch)
				k = link_mem[k-1];
			if (pat_mem[k] == ch)
				k++;
			link_mem[pat_len] = k;
			pfx_len = k;
			pat_len++;
			return 1'b0;
		end
		if (fresh) begin
			text_pos = '0;
			matched  = 0;
		end
		p = int'(text_pos);
		if (text_pos != '1)
			text_pos = text_pos + POS_BITS'(1);
		if (pat_len == 0) begin
			matched = 0;
			return 1'b0;
		end
		k = matched;
		if (k >= pat_len)
			k = 0;
		while (k > 0 && pat_mem[k] != ch)
			k = link_mem[k-1];
		if (pat_mem[k] == ch)
			k++;
		if (k == pat_len) begin
			back = pat_len - 1;
			hit_pos = (p >= back) ? 32'(p - back) : 32'd0;
			matched = link_mem[pat_len-1];
			return 1'b1;
		end
		matched = k;
		return 1'b0;
	endfunction

	// drive one word, wait for it to be taken, then predict
	task automatic send_word(input bit is_text, input logic [7:0] ch, input bit fresh);
		int gap;
		logic [31:0] hit_pos;
		gap = 0;
		if (!calm)
			while ($urandom_range(99) < IDLE_PCT)
				gap++;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= ch;
		s_axis_tuser  <= {fresh, is_text};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (kmp_step(is_text, ch, fresh, hit_pos))
			match_starts_q.push_back(hit_pos);
	endtask

	// a string of words of one mode; only the first may carry the first flag
	task automatic send_str(input bit is_text, input string s, input bit fresh);
		for (int i = 0; i < s.len(); i++)
			send_word(is_text, s[i], fresh && i == 0);
	endtask

	// result side: compare each word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (match_starts_q.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_MAX)
					$display("unexpected match_start %0d", m_axis_tdata);
			end else begin
				want_start = match_starts_q.pop_front();
				if (m_axis_tdata !== want_start) begin
					fail_count++;
					if (fail_count <= REPORT_MAX)
						$display("match_start mismatch: expected %0d, got %0d",
							want_start, m_axis_tdata);
				end
			end
		end
	end

	// result-side back-pressure
	always @(posedge clk) begin
		m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	// watchdog on cycles where no word moves
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// text before any pattern gives nothing
	task automatic test_text_without_pattern();
		send_word(MODE_TEXT, 8'h00, 1'b1);
		send_word(MODE_TEXT, 8'hFF, 1'b0);
		send_word(MODE_TEXT, 8'h5A, 1'b0);
	endtask

	// unmarked pattern word on an empty pattern starts it
	task automatic test_pattern_start_unmarked();
		send_str(MODE_PATTERN, "ab", 1'b0);
		send_str(MODE_TEXT, "xabab", 1'b1);
	endtask

	// overlapping hits through the failure links
	task automatic test_overlap();
		send_str(MODE_PATTERN, "aab", 1'b1);
		send_str(MODE_TEXT, "aaabaab", 1'b1);
		send_str(MODE_PATTERN, "aa", 1'b1);
		send_str(MODE_TEXT, "aaaa", 1'b1);
	endtask

	// byte extremes, and a first-marked text word cutting a partial match
	task automatic test_byte_extremes();
		send_word(MODE_PATTERN, 8'h00, 1'b1);
		send_word(MODE_PATTERN, 8'hFF, 1'b0);
		send_word(MODE_TEXT, 8'hFF, 1'b1);
		send_word(MODE_TEXT, 8'h00, 1'b0);
		send_word(MODE_TEXT, 8'hFF, 1'b0);
		send_word(MODE_TEXT, 8'h00, 1'b1);
		send_word(MODE_TEXT, 8'h00, 1'b1);
		send_word(MODE_TEXT, 8'hFF, 1'b0);
	endtask

	// a new pattern mid-text clears the match but keeps the position
	task automatic test_new_pattern_mid_text();
		send_str(MODE_PATTERN, "ab", 1'b1);
		send_str(MODE_TEXT, "a", 1'b1);
		send_str(MODE_PATTERN, "b", 1'b1);
		send_str(MODE_TEXT, "b", 1'b0);
	endtask

	// words past capacity are dropped; a full-size pattern still matches
	task automatic test_pattern_overflow();
		send_word(MODE_PATTERN, "a", 1'b1);
		for (int i = 1; i < PAT_CAP; i++)
			send_word(MODE_PATTERN, "a", 1'b0);
		send_str(MODE_PATTERN, "bc", 1'b0);
		for (int i = 0; i < PAT_CAP + 2; i++)
			send_word(MODE_TEXT, "a", i == 0);
	endtask

	// mostly patterns and texts over a small alphabet, with some noise
	task automatic test_random_traffic(input int n_items);
		int sent;
		int r;
		int len;
		int j;
		logic [7:0] ch;
		sent = 0;
		while (sent < n_items) begin
			calm = (sent >= n_items / 3) && (sent < n_items / 2);
			r = $urandom_range(99);
			if (r < 10) begin
				send_word(1'($urandom_range(1)), 8'($urandom_range(255)),
					1'($urandom_range(1)));
				sent++;
			end else if (r < 25) begin
				alpha_base = 8'($urandom_range(255));
				alpha_n    = $urandom_range(1, 3);
				len = ($urandom_range(19) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
				cur_pat.delete();
				for (int i = 0; i < len; i++) begin
					ch = alpha_base + 8'($urandom_range(alpha_n - 1));
					cur_pat.push_back(ch);
					// occasionally leave the first flag off so the words append
					send_word(MODE_PATTERN, ch, i == 0 && $urandom_range(9) != 0);
				end
				sent += len;
			end else begin
				len = $urandom_range(4, 30);
				j = 0;
				while (j < len) begin
					if (cur_pat.size() > 0 && $urandom_range(99) < 30) begin
						foreach (cur_pat[i]) begin
							send_word(MODE_TEXT, cur_pat[i], j == 0 && $urandom_range(9) < 7);
							j++;
						end
					end else begin
						if ($urandom_range(19) == 0)
							ch = 8'($urandom_range(255));
						else
							ch = alpha_base + 8'($urandom_range(alpha_n > 0 ? alpha_n - 1 : 0));
						send_word(MODE_TEXT, ch, j == 0 && $urandom_range(9) < 7);
						j++;
					end
				end
				sent += j;
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		pat_len    = 0;
		pfx_len    = 0;
		matched    = 0;
		text_pos   = '0;
		fail_count = 0;
		idle_cycles = 0;
		calm       = 1'b0;
		alpha_base = 8'h61;
		alpha_n    = 2;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_text_without_pattern();
		test_pattern_start_unmarked();
		test_overlap();
		test_byte_extremes();
		test_new_pattern_mid_text();
		test_pattern_overflow();
		test_random_traffic(340);
		s_axis_tvalid <= 1'b0;

		while (match_starts_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && match_starts_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== kmp_stream_matcher_core.f =====
rtl/kmpsm_pkg.sv
rtl/kmpsm_ram.sv
rtl/kmp_stream_matcher_core.sv
bench/tb_top.sv
